// ----- design/lhbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbp_pkg
// Types and constants shared by the local history branch predictor modules.
// ----------------------------------------------------------------------------
package lhbp_pkg;

  localparam int ENTRIES      = 256;
  localparam int INDEX_W      = $clog2(ENTRIES);
  localparam int ADDR_W       = 32;
  localparam int TAG_W        = ADDR_W - INDEX_W;
  localparam int HISTORY_BITS = 4;
  localparam int NUM_CTRS     = 16;
  localparam int TARGET_W     = 32;

  localparam logic CMD_COND     = 1'b0;
  localparam logic CMD_INDIRECT = 1'b1;

  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_MIN = 2'd0;

  typedef struct packed {
    logic                cmd;
    logic [ADDR_W-1:0]   branch_addr;
    logic                taken;
    logic [TARGET_W-1:0] actual_target;
  } in_item_t;

  typedef struct packed {
    logic                entry_hit;
    logic                predicted_taken;
    logic [TARGET_W-1:0] predicted_target;
    logic                mispredict;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]              tag;
    logic [HISTORY_BITS-1:0]       history;
    logic [NUM_CTRS-1:0][1:0]      counters;
    logic [TARGET_W-1:0]           target;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic in_load;   // capture the input transaction
    logic rd_en;     // read table entry and valid bit
    logic update;    // write back entry and load the result register
  } lhbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_valid;
  } lhbp_status_t;

endpackage

// ----- design/lhbp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbp_ctrl
// Sequencer: accept, table read, update/write-back.
// ----------------------------------------------------------------------------
module lhbp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  input  lhbp_pkg::lhbp_status_t status,
  output lhbp_pkg::lhbp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  // result register is free, or is being drained this cycle
  assign slot_free = !status.out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd.in_load = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (slot_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/lhbp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbp_datapath
// Entry table, valid bits, prediction and counter/history update, result reg.
// ----------------------------------------------------------------------------
module lhbp_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  lhbp_pkg::in_item_t     in_data,
  input  lhbp_pkg::lhbp_cmd_t    cmd,
  output lhbp_pkg::lhbp_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lhbp_pkg::out_item_t    out_data
);

  lhbp_pkg::entry_t   entry_mem [lhbp_pkg::ENTRIES];
  logic [lhbp_pkg::ENTRIES-1:0] entry_valid;

  lhbp_pkg::in_item_t item;
  lhbp_pkg::entry_t   rd_entry;
  logic               rd_valid;

  logic [lhbp_pkg::INDEX_W-1:0] slot;
  logic [lhbp_pkg::TAG_W-1:0]   tag;
  logic                         hit;
  lhbp_pkg::entry_t             cur;
  lhbp_pkg::entry_t             wr_entry;
  logic [1:0]                   ctr;
  logic [1:0]                   ctr_next;
  logic                         pred_taken;
  lhbp_pkg::out_item_t          result;

  assign slot = item.branch_addr[lhbp_pkg::INDEX_W-1:0];
  assign tag  = item.branch_addr[lhbp_pkg::ADDR_W-1:lhbp_pkg::INDEX_W];
  assign hit  = rd_valid && (rd_entry.tag == tag);

  always_comb begin
    // a miss allocates a cleared entry
    if (hit) begin
      cur = rd_entry;
    end else begin
      cur     = '0;
      cur.tag = tag;
    end
    ctr        = cur.counters[cur.history];
    pred_taken = !ctr[1];
    ctr_next   = ctr;
    if (item.taken) begin
      if (ctr != lhbp_pkg::CTR_MIN) ctr_next = ctr - 2'd1;
    end else begin
      if (ctr != lhbp_pkg::CTR_MAX) ctr_next = ctr + 2'd1;
    end

    wr_entry = cur;
    result.entry_hit = hit;
    if (item.cmd == lhbp_pkg::CMD_COND) begin
      wr_entry.counters[cur.history] = ctr_next;
      wr_entry.history = lhbp_pkg::HISTORY_BITS'({cur.history, item.taken});
      result.predicted_taken  = pred_taken;
      result.predicted_target = '0;
      result.mispredict       = (pred_taken != item.taken);
    end else begin
      wr_entry.target = item.actual_target;
      result.predicted_taken  = 1'b0;
      result.predicted_target = cur.target;
      result.mispredict       = (cur.target != item.actual_target);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) item <= in_data;
    if (cmd.rd_en) begin
      rd_entry <= entry_mem[slot];
      rd_valid <= entry_valid[slot];
    end
    if (cmd.update) begin
      entry_mem[slot] <= wr_entry;
      out_data        <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.update) begin
        entry_valid[slot] <= 1'b1;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_valid = out_valid;

endmodule

// ----- design/local_history_branch_predictor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Tagged direct-mapped local history predictor with last-target buffer.
// ----------------------------------------------------------------------------
//  channel | signals                        | transaction
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | one resolved branch event
//  out     | out_valid, out_ready, out_data | prediction and mispredict flag
//
//  Each transaction passes through capture, table read (registered RAM read
//  port) and write-back. The single-port table read-modify-write sets the rate.
//  Reset clears all valid bits at once; no clearing pass.
//  in_ready is high only in the idle state; a result waiting in the output
//  register holds the write-back step until it is taken.
// ----------------------------------------------------------------------------
module local_history_branch_predictor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lhbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lhbp_pkg::out_item_t out_data
);

  lhbp_pkg::lhbp_cmd_t    cmd;
  lhbp_pkg::lhbp_status_t status;

  lhbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lhbp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for local_history_branch_predictor. Resolved branch events are
// sent over the input channel. A behavioral copy of the branch table (tags,
// local histories, 2-bit counters, last targets) computes each prediction and
// mispredict flag. A checker compares every result against the oldest
// prediction. Phases cover directed corner cases, random traffic with idle and
// stall patterns, a long output hold, and a pause until results drain.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int HOT_COUNT   = 16;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lhbp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lhbp_pkg::out_item_t out_data;

  // shadow of the branch table
  logic                                   tbl_valid [lhbp_pkg::ENTRIES];
  logic [lhbp_pkg::TAG_W-1:0]             tbl_tag   [lhbp_pkg::ENTRIES];
  logic [lhbp_pkg::HISTORY_BITS-1:0]      tbl_hist  [lhbp_pkg::ENTRIES];
  logic [lhbp_pkg::NUM_CTRS-1:0][1:0]     tbl_ctrs  [lhbp_pkg::ENTRIES];
  logic [lhbp_pkg::TARGET_W-1:0]          tbl_target[lhbp_pkg::ENTRIES];

  lhbp_pkg::out_item_t expected_results[$];
  int                  fail_count = 0;
  int                  send_idle_pct = 0;
  int                  ready_stall_pct = 0;
  logic                hold_output = 1'b0;
  event                start_hold;

  // addresses reused often so entries hit, histories fill and counters train
  logic [lhbp_pkg::ADDR_W-1:0]   hot_addr  [HOT_COUNT];
  logic [lhbp_pkg::TARGET_W-1:0] hot_target[HOT_COUNT];
  int                            loop_count[HOT_COUNT];

  local_history_branch_predictor dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Lookup, allocate on miss, predict, then train the entry.
  function automatic lhbp_pkg::out_item_t predict_branch(input lhbp_pkg::in_item_t ev);
    logic [lhbp_pkg::INDEX_W-1:0]      slot;
    logic [lhbp_pkg::TAG_W-1:0]        tg;
    logic [lhbp_pkg::HISTORY_BITS-1:0] h;
    logic [1:0]                        ctr;
    lhbp_pkg::out_item_t               r;
    slot = ev.branch_addr[lhbp_pkg::INDEX_W-1:0];
    tg   = ev.branch_addr[lhbp_pkg::ADDR_W-1:lhbp_pkg::INDEX_W];
    r    = '0;
    r.entry_hit = tbl_valid[slot] && (tbl_tag[slot] == tg);
    if (!r.entry_hit) begin
      tbl_valid[slot]  = 1'b1;
      tbl_tag[slot]    = tg;
      tbl_hist[slot]   = '0;
      tbl_ctrs[slot]   = '0;
      tbl_target[slot] = '0;
    end
    if (ev.cmd == lhbp_pkg::CMD_COND) begin
      h   = tbl_hist[slot];
      ctr = tbl_ctrs[slot][h];
      r.predicted_taken = ~ctr[1];
      r.mispredict      = (r.predicted_taken != ev.taken);
      if (ev.taken) begin
        if (ctr != lhbp_pkg::CTR_MIN) ctr = ctr - 2'd1;
      end else begin
        if (ctr != lhbp_pkg::CTR_MAX) ctr = ctr + 2'd1;
      end
      tbl_ctrs[slot][h] = ctr;
      tbl_hist[slot]    = lhbp_pkg::HISTORY_BITS'({h, ev.taken});
    end else begin
      r.predicted_target = tbl_target[slot];
      r.mispredict       = (tbl_target[slot] != ev.actual_target);
      tbl_target[slot]   = ev.actual_target;
    end
    return r;
  endfunction

  function automatic lhbp_pkg::in_item_t branch_event(
      input logic cmd, input logic [lhbp_pkg::ADDR_W-1:0] addr,
      input logic tk, input logic [lhbp_pkg::TARGET_W-1:0] tgt);
    lhbp_pkg::in_item_t ev;
    ev.cmd           = cmd;
    ev.branch_addr   = addr;
    ev.taken         = tk;
    ev.actual_target = tgt;
    return ev;
  endfunction

  function automatic lhbp_pkg::in_item_t random_branch();
    lhbp_pkg::in_item_t ev;
    int                 k;
    ev.cmd           = ($urandom_range(99) < 30) ? lhbp_pkg::CMD_INDIRECT : lhbp_pkg::CMD_COND;
    ev.taken         = 1'($urandom_range(1));
    ev.actual_target = $urandom;
    ev.branch_addr   = $urandom;
    if ($urandom_range(99) < 85) begin
      k = $urandom_range(HOT_COUNT - 1);
      ev.branch_addr = hot_addr[k];
      // per-address behavior: biased taken, biased not taken, random, loop of 3
      case (k % 4)
        0: ev.taken = ($urandom_range(9) != 0);
        1: ev.taken = ($urandom_range(9) == 0);
        3: begin
          ev.taken = (loop_count[k] % 3 != 0);
          loop_count[k]++;
        end
        default: ;
      endcase
      if (ev.cmd == lhbp_pkg::CMD_INDIRECT && $urandom_range(99) < 75) begin
        ev.actual_target = hot_target[k];
      end
    end
    return ev;
  endfunction

  task automatic send_event(input lhbp_pkg::in_item_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_branch(ev));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    send_event(branch_event(lhbp_pkg::CMD_COND, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
    send_event(branch_event(lhbp_pkg::CMD_COND, 32'h0000_0000, 1'b0, 32'h0000_0000));
    send_event(branch_event(lhbp_pkg::CMD_INDIRECT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
    send_event(branch_event(lhbp_pkg::CMD_INDIRECT, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF));
    send_event(branch_event(lhbp_pkg::CMD_INDIRECT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000));
    // same slot, other tag: entry is evicted and cleared
    send_event(branch_event(lhbp_pkg::CMD_COND, 32'h0000_0100, 1'b0, 32'h5555_5555));
    send_event(branch_event(lhbp_pkg::CMD_INDIRECT, 32'h0000_0000, 1'b0, 32'h1234_5678));
    send_event(branch_event(lhbp_pkg::CMD_COND, 32'hFFFF_FF00, 1'b1, 32'hAAAA_AAAA));
    // not-taken run saturates counter 0 at the top
    repeat (7) send_event(branch_event(lhbp_pkg::CMD_COND, 32'h0000_0040, 1'b0, 32'h0));
    // taken run walks history to all ones and saturates at the bottom
    repeat (6) send_event(branch_event(lhbp_pkg::CMD_COND, 32'h0000_0040, 1'b1, 32'h0));
    send_event(branch_event(lhbp_pkg::CMD_INDIRECT, 32'h0000_0040, 1'b0, 32'h8000_0001));
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    repeat (count) send_event(random_branch());
  endtask

  // receiver holds off while the sender keeps offering; input must back up
  task automatic test_output_hold();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    -> start_hold;
    repeat (30) send_event(random_branch());
  endtask

  task automatic test_drain_pause();
    send_idle_pct   = 0;
    ready_stall_pct = 30;
    repeat (15) send_event(random_branch());
    wait_for_results();
    repeat (15) send_event(random_branch());
  endtask

  always @(posedge clk) begin : result_check
    lhbp_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.entry_hit !== want.entry_hit) begin
          $error("entry_hit: expected %0d, got %0d", want.entry_hit, out_data.entry_hit);
          fail_count++;
        end
        if (out_data.predicted_taken !== want.predicted_taken) begin
          $error("predicted_taken: expected %0d, got %0d",
                 want.predicted_taken, out_data.predicted_taken);
          fail_count++;
        end
        if (out_data.predicted_target !== want.predicted_target) begin
          $error("predicted_target: expected %h, got %h",
                 want.predicted_target, out_data.predicted_target);
          fail_count++;
        end
        if (out_data.mispredict !== want.mispredict) begin
          $error("mispredict: expected %0d, got %0d", want.mispredict, out_data.mispredict);
          fail_count++;
        end
      end
    end
    if (hold_output) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  initial begin : output_hold
    forever begin
      @(start_hold);
      hold_output <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_output <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < lhbp_pkg::ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < HOT_COUNT; i++) begin
      hot_addr[i]   = $urandom;
      hot_target[i] = $urandom;
      loop_count[i] = 0;
    end
    // last few share a slot with earlier ones under another tag
    for (int i = 12; i < HOT_COUNT; i++) begin
      hot_addr[i][lhbp_pkg::INDEX_W-1:0] = hot_addr[i - 12][lhbp_pkg::INDEX_W-1:0];
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(200, 0, 0);
    test_output_hold();
    test_random_traffic(150, 85, 0);
    test_drain_pause();
    test_random_traffic(150, 0, 85);
    test_random_traffic(200, 25, 25);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
